// File: rtl/srfr_pkg.sv
// ----------------------------------------------------------------------------
// srfr_pkg
// Shared types and codes for the sample ring filtered readout block.
// ----------------------------------------------------------------------------
package srfr_pkg;

  // Sample store geometry; the depth is a power of two.
  localparam int SAMPLE_DEPTH = 4096;
  localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);

  // Request command codes.
  localparam logic [2:0] CMD_WRITE     = 3'd0;
  localparam logic [2:0] CMD_READ_ANA  = 3'd1;
  localparam logic [2:0] CMD_READ_DIG  = 3'd2;
  localparam logic [2:0] CMD_SOFT_RST  = 3'd3;
  localparam logic [2:0] CMD_HARD_RST  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_DELAY     = 3'd0;
  localparam logic [2:0] REG_INTERVAL  = 3'd1;
  localparam logic [2:0] REG_FILTER    = 3'd2;
  localparam logic [2:0] REG_SCALE     = 3'd3;
  localparam logic [2:0] REG_REF       = 3'd4;
  localparam logic [2:0] REG_AC        = 3'd5;
  localparam logic [2:0] REG_TWELVE    = 3'd6;

  // Filter select codes.
  localparam logic [1:0] FILT_NONE     = 2'd0;
  localparam logic [1:0] FILT_AVG      = 2'd1;

  // Operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_WR,
    OP_CONV,
    OP_AVG,
    OP_RAW,
    OP_BIT,
    OP_CLR
  } srfr_op_e;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_AVG,
    ST_DIV,
    ST_MUL,
    ST_CVT,
    ST_CLR
  } srfr_state_e;

  // Configuration register set.
  typedef struct packed {
    logic        [11:0] delay;
    logic        [7:0]  interval;
    logic        [1:0]  filt;
    logic signed [31:0] scale;
    logic signed [31:0] ref_lvl;
    logic               ac;
    logic               twelve;
  } srfr_cfg_t;

  // Queue entry without the address.
  typedef struct packed {
    srfr_op_e           op;
    logic        [2:0]  bitsel;
    logic        [7:0]  win;
    logic signed [15:0] sample;
  } srfr_meta_t;

endpackage

// File: rtl/sample_ring_filtered_readout.sv
// ----------------------------------------------------------------------------
// sample_ring_filtered_readout
// Capture ring of samples with moving average and Q16.16 voltage readout.
// ----------------------------------------------------------------------------
// A raw or digital read passes the queue, the memory read and the result register;
// a converted read adds the multiply and convert steps, an empty window takes only
// those; an average walks the window and divides first. A hard reset clears the store.
// Requests are taken every cycle while the two-entry queue has room.
// Results are single-cycle strobes; the receiver cannot stall.
// Reset clears control state only; the store is undefined until written or cleared.
module sample_ring_filtered_readout import srfr_pkg::*; #(
  parameter int MAX_WINDOW = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         command_i,
  input  logic [15:0]        write_address_i,
  input  logic signed [15:0] sample_value_i,
  input  logic [11:0]        position_i,
  output logic               done_o,
  output logic signed [31:0] voltage_o,
  output logic               bit_value_o
);

  localparam int AW = SAMPLE_AW;

  srfr_cfg_t     cfg_q;
  logic          push, pop, empty, full;
  srfr_meta_t    f_meta, q_meta;
  logic [AW-1:0] f_addr, q_addr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay    <= 12'd0;
      cfg_q.interval <= 8'd1;
      cfg_q.filt     <= FILT_NONE;
      cfg_q.scale    <= 32'sd16777216;
      cfg_q.ref_lvl  <= 32'sd0;
      cfg_q.ac       <= 1'b0;
      cfg_q.twelve   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DELAY:    cfg_q.delay    <= cfg_data_i[11:0];
        REG_INTERVAL: cfg_q.interval <= cfg_data_i[7:0];
        REG_FILTER:   cfg_q.filt     <= cfg_data_i[1:0];
        REG_SCALE:    cfg_q.scale    <= cfg_data_i;
        REG_REF:      cfg_q.ref_lvl  <= cfg_data_i;
        REG_AC:       cfg_q.ac       <= cfg_data_i[0];
        REG_TWELVE:   cfg_q.twelve   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign busy_o = full;

  // Front end.
  srfr_front #(.AW(AW), .MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .start_i         (start_i),
    .command_i       (command_i),
    .write_address_i (write_address_i),
    .sample_value_i  (sample_value_i),
    .position_i      (position_i),
    .full_i          (full),
    .push_o          (push),
    .meta_o          (f_meta),
    .addr_o          (f_addr)
  );

  // Decoupling queue.
  srfr_queue #(.AW(AW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .meta_i  (f_meta),
    .addr_i  (f_addr),
    .pop_i   (pop),
    .meta_o  (q_meta),
    .addr_o  (q_addr),
    .empty_o (empty),
    .full_o  (full)
  );

  // Back end.
  srfr_back #(.AW(AW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .meta_i      (q_meta),
    .addr_i      (q_addr),
    .pop_o       (pop),
    .done_o      (done_o),
    .voltage_o   (voltage_o),
    .bit_value_o (bit_value_o)
  );

endmodule

// File: rtl/srfr_front.sv
// ----------------------------------------------------------------------------
// srfr_front
// Accepts requests, tracks the newest address and turns each write, read and
// hard reset request into a queue entry with its resolved memory address.
// ----------------------------------------------------------------------------
module srfr_front import srfr_pkg::*; #(
  parameter int AW        = 12,
  parameter int MAX_WINDOW = 255
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srfr_cfg_t         cfg_i,
  input  logic              start_i,
  input  logic [2:0]        command_i,
  input  logic [15:0]       write_address_i,
  input  logic signed [15:0] sample_value_i,
  input  logic [11:0]       position_i,
  input  logic              full_i,
  output logic              push_o,
  output srfr_meta_t        meta_o,
  output logic [AW-1:0]     addr_o
);

  localparam int DW = (AW + 3 > 21) ? AW + 3 : 21;
  localparam logic [11:0] MaxWin = 12'(MAX_WINDOW);

  logic [AW-1:0] newest_q, newest_d;
  logic [19:0]   step;
  logic [DW-1:0] span;
  logic [AW-1:0] ana_addr;
  logic [AW-1:0] dig_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    win;
  logic          accept;

  // Distance and window arithmetic.
  assign accept   = start_i && !full_i;
  assign step     = cfg_i.interval * position_i;
  assign span     = DW'(cfg_i.delay) + DW'(step);
  assign ana_addr = newest_q - span[AW-1:0];
  assign dig_addr = newest_q - span[AW+2:3];
  assign wr_addr  = AW'(write_address_i);
  assign win      = ({4'b0, cfg_i.interval} > MaxWin) ? MaxWin[7:0] : cfg_i.interval;

  // Request classification.
  always_comb begin
    newest_d      = newest_q;
    push_o        = 1'b0;
    meta_o.op     = OP_WR;
    meta_o.bitsel = span[2:0];
    meta_o.win    = win;
    meta_o.sample = sample_value_i;
    addr_o        = ana_addr;
    if (accept) begin
      unique case (command_i)
        CMD_WRITE: begin
          push_o   = 1'b1;
          addr_o   = wr_addr;
          newest_d = wr_addr;
        end
        CMD_READ_ANA: begin
          push_o = 1'b1;
          if (cfg_i.filt == FILT_NONE) begin
            meta_o.op = OP_CONV;
          end else if (cfg_i.filt == FILT_AVG) begin
            meta_o.op = OP_AVG;
            addr_o    = ana_addr - AW'({1'b0, win[7:1]});
          end else begin
            meta_o.op = OP_RAW;
          end
        end
        CMD_READ_DIG: begin
          push_o    = 1'b1;
          meta_o.op = OP_BIT;
          addr_o    = dig_addr;
        end
        CMD_SOFT_RST: begin
          newest_d = '0;
        end
        CMD_HARD_RST: begin
          // The back end clears the store in order with the other requests.
          push_o    = 1'b1;
          meta_o.op = OP_CLR;
          newest_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Newest address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= '0;
    end else begin
      newest_q <= newest_d;
    end
  end

endmodule

// File: rtl/srfr_queue.sv
// ----------------------------------------------------------------------------
// srfr_queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module srfr_queue import srfr_pkg::*; #(
  parameter int AW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  srfr_meta_t    meta_i,
  input  logic [AW-1:0] addr_i,
  input  logic          pop_i,
  output srfr_meta_t    meta_o,
  output logic [AW-1:0] addr_o,
  output logic          empty_o,
  output logic          full_o
);

  srfr_meta_t    meta_q [2];
  logic [AW-1:0] addr_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign meta_o  = meta_q[rp_q];
  assign addr_o  = addr_q[rp_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      meta_q[wp_q] <= meta_i;
      addr_q[wp_q] <= addr_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// File: rtl/srfr_back.sv
// ----------------------------------------------------------------------------
// srfr_back
// Holds the sample memory and carries out queued requests: writes, reads,
// the moving average walk, the divide, the voltage conversion and the
// clearing pass of a hard reset.
// ----------------------------------------------------------------------------
module srfr_back import srfr_pkg::*; #(
  parameter int AW = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srfr_cfg_t          cfg_i,
  input  logic               empty_i,
  input  srfr_meta_t         meta_i,
  input  logic [AW-1:0]      addr_i,
  output logic               pop_o,
  output logic               done_o,
  output logic signed [31:0] voltage_o,
  output logic               bit_value_o
);

  localparam logic signed [49:0] SatMax = 50'sd2147483647;
  localparam logic signed [49:0] SatMin = -50'sd2147483648;

  srfr_state_e state_q, state_d;
  srfr_op_e    op_q, op_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  win_q, win_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [7:0]  cnt_q, cnt_d;
  logic signed [23:0] acc_q, acc_d;
  logic [23:0] quo_q, quo_d;
  logic [7:0]  rem_q, rem_d;
  logic        neg_q, neg_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic signed [15:0] val_q, val_d;
  logic signed [47:0] prod_q, prod_d;
  logic        done_q, done_d;
  logic signed [31:0] volt_q, volt_d;
  logic        bitv_q, bitv_d;

  logic [15:0] mem [2**AW];
  logic signed [15:0] rdata_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [15:0] wr_data;
  logic        we;

  logic signed [23:0] acc_sum;
  logic [23:0] acc_abs;
  logic [8:0]  trial;
  logic signed [49:0] ref_ext, tot, fin;

  // Sample memory with registered read.
  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
    rdata_q <= mem[rd_addr];
  end

  // Datapath helpers.
  assign acc_sum = acc_q + {{8{rdata_q[15]}}, rdata_q};
  assign acc_abs = acc_sum[23] ? 24'(-acc_sum) : acc_sum;
  assign trial   = {rem_q, quo_q[23]};
  assign ref_ext = {{18{cfg_i.ref_lvl[31]}}, cfg_i.ref_lvl};
  assign tot     = {{10{prod_q[47]}}, prod_q[47:8]}
                 + (cfg_i.twelve ? 50'sd0 : ref_ext)
                 - (cfg_i.ac ? ref_ext : 50'sd0);
  assign fin     = cfg_i.twelve ? (tot >>> 4) : tot;

  // Sequencer next state and outputs.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    bit_d   = bit_q;
    win_d   = win_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    dcnt_d  = dcnt_q;
    val_d   = val_q;
    prod_d  = prod_q;
    done_d  = 1'b0;
    volt_d  = volt_q;
    bitv_d  = bitv_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    wr_addr = addr_i;
    wr_data = meta_i.sample;
    rd_addr = addr_i;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          op_d  = meta_i.op;
          bit_d = meta_i.bitsel;
          win_d = meta_i.win;
          if (meta_i.op == OP_WR) begin
            we = 1'b1;
          end else if (meta_i.op == OP_CLR) begin
            ptr_d   = '0;
            state_d = ST_CLR;
          end else if (meta_i.op == OP_AVG) begin
            if (meta_i.win == 8'd0) begin
              val_d   = '0;
              state_d = ST_MUL;
            end else begin
              ptr_d   = addr_i + AW'(1);
              cnt_d   = 8'd1;
              acc_d   = '0;
              state_d = ST_AVG;
            end
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_CLR: begin
        // One entry cleared per cycle over the whole store.
        we      = 1'b1;
        wr_addr = ptr_q;
        wr_data = '0;
        ptr_d   = ptr_q + AW'(1);
        if (ptr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        if (op_q == OP_CONV) begin
          val_d   = rdata_q;
          state_d = ST_MUL;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (op_q == OP_BIT) begin
            volt_d = '0;
            bitv_d = rdata_q[bit_q];
          end else begin
            volt_d = {rdata_q, 16'h0000};
            bitv_d = 1'b0;
          end
        end
      end
      ST_AVG: begin
        rd_addr = ptr_q;
        acc_d   = acc_sum;
        if (cnt_q == win_q) begin
          neg_d   = acc_sum[23];
          quo_d   = acc_abs;
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = ST_DIV;
        end else begin
          ptr_d = ptr_q + AW'(1);
          cnt_d = cnt_q + 8'd1;
        end
      end
      ST_DIV: begin
        // One restoring divide step per cycle.
        if (trial >= {1'b0, win_q}) begin
          rem_d = 8'(trial - {1'b0, win_q});
          quo_d = {quo_q[22:0], 1'b1};
        end else begin
          rem_d = trial[7:0];
          quo_d = {quo_q[22:0], 1'b0};
        end
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd23) begin
          val_d   = neg_q ? 16'(-quo_d[15:0]) : quo_d[15:0];
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = val_q * cfg_i.scale;
        state_d = ST_CVT;
      end
      ST_CVT: begin
        done_d = 1'b1;
        bitv_d = 1'b0;
        if (fin > SatMax) begin
          volt_d = 32'sh7fffffff;
        end else if (fin < SatMin) begin
          volt_d = 32'sh80000000;
        end else begin
          volt_d = fin[31:0];
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      dcnt_q  <= dcnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    bit_q  <= bit_d;
    win_q  <= win_d;
    ptr_q  <= ptr_d;
    acc_q  <= acc_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    val_q  <= val_d;
    prod_q <= prod_d;
    volt_q <= volt_d;
    bitv_q <= bitv_d;
  end

  assign done_o      = done_q;
  assign voltage_o   = volt_q;
  assign bit_value_o = bitv_q;

`ifndef SYNTHESIS
  // A result follows only a read or a conversion step.
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == ST_RD || $past(state_q) == ST_CVT))
    else $error("result without a finishing step");
  // The divider never runs with an empty window.
  a_div_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (win_q != 8'd0))
    else $error("divide by zero window");
  // A result never carries both a voltage and a bit.
  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (volt_q == 32'sd0 || bitv_q == 1'b0))
    else $error("both result fields set");
`endif

endmodule
